// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit: commands,
// sequencer states and the request/status bundle of the iterative unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Command codes carried in the low bits of the input data
    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_NORM = 3'd4;

    // Stream field widths
    localparam int CMD_W  = 3;
    localparam int FLD_W  = 32;
    localparam int DEN_W  = 31;
    localparam int IN_W   = 136;
    localparam int OUT_W  = 64;

    // Operations of the iterative unit
    typedef enum logic [1:0] {
        U_MUL,
        U_DIV,
        U_GCD
    } t_uop;

    typedef struct packed {
        logic start;
        t_uop op;
    } t_ureq;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ustat;

    // Which fraction the canonical-form steps are working on
    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } t_phase;

    // Main sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_C0,
        S_C1,
        S_C2,
        S_C3,
        S_CRET,
        S_MUL1,
        S_MUL2,
        S_ADD_G,
        S_ADD_D,
        S_ADD_L,
        S_T1M,
        S_T1D,
        S_T2M,
        S_T2D
    } t_state;

endpackage

// ===== rtl/rau_unit.sv =====
// ----------------------------------------------------------------------------
// rau_unit
// Shared iterative arithmetic unit: shift-add multiply (low WIDTH bits),
// restoring unsigned divide and binary gcd, one step per cycle.
// ----------------------------------------------------------------------------
module rau_unit #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rau_pkg::t_ureq     i_req,
    input  logic [WIDTH-1:0]   i_x,
    input  logic [WIDTH-1:0]   i_y,
    output rau_pkg::t_ustat    o_stat,
    output logic [WIDTH-1:0]   o_res
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_uop             r_op, n_op;
    logic [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0] r_b, n_b;
    logic [WIDTH:0]   r_acc, n_acc;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_res, n_res;

    logic [WIDTH:0]   w_sh;
    logic [WIDTH:0]   w_diff;

    // Divide step: shift in next dividend bit, trial subtract
    assign w_sh   = {r_acc[WIDTH-1:0], r_a[WIDTH-1]};
    assign w_diff = w_sh - {1'b0, r_b};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    // One step of the selected operation per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_res  = r_res;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy = 1'b1;
                n_op   = i_req.op;
                n_a    = i_x;
                n_b    = i_y;
                n_acc  = '0;
                n_cnt  = '0;
            end
        end else begin
            unique case (r_op)
                U_MUL: begin
                    if (r_b[0]) begin
                        n_acc = r_acc + {1'b0, r_a};
                    end
                    n_a   = r_a << 1;
                    n_b   = r_b >> 1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                        n_res  = n_acc[WIDTH-1:0];
                    end
                end
                U_DIV: begin
                    if (!w_diff[WIDTH]) begin
                        n_acc = w_diff;
                        n_a   = {r_a[WIDTH-2:0], 1'b1};
                    end else begin
                        n_acc = w_sh;
                        n_a   = {r_a[WIDTH-2:0], 1'b0};
                    end
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                        n_res  = n_a;
                    end
                end
                U_GCD: begin
                    if (r_a == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                        n_res  = r_b << r_cnt;
                    end else if (r_b == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                        n_res  = r_a << r_cnt;
                    end else if (!r_a[0] && !r_b[0]) begin
                        n_a   = r_a >> 1;
                        n_b   = r_b >> 1;
                        n_cnt = r_cnt + 1'b1;
                    end else if (!r_a[0]) begin
                        n_a = r_a >> 1;
                    end else if (!r_b[0]) begin
                        n_b = r_b >> 1;
                    end else if (r_a >= r_b) begin
                        n_a = r_a - r_b;
                    end else begin
                        n_b = r_b - r_a;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    n_res  = '0;
                end
            endcase
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_res;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions, or normalizes one,
// and returns the result in reduced canonical form.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s side): one transfer per item carrying the command and
//   the two fractions A and B. Output stream (m side): one transfer per item
//   with the reduced numerator, positive denominator and an error flag.
//   A zero or overflowing result denominator, or an unused command, gives
//   0/1 with the flag set.
//   Sequencing: each item is worked through one shared multiply/divide/gcd
//   unit under a sequencer. One canonical form takes a gcd and two divides;
//   add/subtract needs three of them plus a gcd and six multiply/divide
//   steps, and multiply and divide need three of them plus two multiplies.
//   One item is in work at a time; s_tready is high only while the
//   sequencer is idle.
//   The result sits in an output register; a new item is taken while it
//   waits, and the sequencer holds the next result until the register frees.
//   Reset (synchronous, active low) empties the output register and returns
//   the sequencer to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // command[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
    input  logic [rau_pkg::IN_W-1:0]   i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // res_num[31:0], res_den[62:32], status[63]
    output logic [rau_pkg::OUT_W-1:0]  o_m_tdata
);
    import rau_pkg::*;

    localparam logic [WIDTH-1:0] WSIGN = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] WONE  = WIDTH'(1);

    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
        mag = v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [2:0]       r_cmd, n_cmd;
    logic [WIDTH-1:0] r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic [WIDTH-1:0] r_cn, n_cn, r_cd, n_cd, r_t, n_t;
    logic             r_ng, n_ng, r_cok, n_cok, r_qneg, n_qneg;
    logic             r_ovalid;
    logic [FLD_W-1:0] r_onum;
    logic [DEN_W-1:0] r_oden;
    logic             r_ostat;

    t_ureq            w_req;
    t_ustat           u_stat;
    logic [WIDTH-1:0] w_ux, w_uy, u_res;
    logic             w_load, w_out_free, w_fit, w_ok;

    logic [2:0]              w_cmd;
    logic signed [FLD_W-1:0] w_a_num, w_a_den, w_b_num, w_b_den;
    logic [WIDTH-1:0]        w_n1, w_nm, w_dm, w_opn, w_opd, w_umag, w_q;

    // Unpack input fields
    assign w_cmd   = i_s_tdata[2:0];
    assign w_a_num = i_s_tdata[34:3];
    assign w_a_den = i_s_tdata[66:35];
    assign w_b_num = i_s_tdata[98:67];
    assign w_b_den = i_s_tdata[130:99];

    // Sign fold for canonical form: sign moves to the numerator
    assign w_n1   = r_cd[WIDTH-1] ? (~r_cn + 1'b1) : r_cn;
    assign w_nm   = mag(w_n1);
    assign w_dm   = mag(r_cd);
    assign w_opn  = r_cok ? r_cn : '0;
    assign w_opd  = r_cok ? r_cd : WONE;
    assign w_umag = mag(u_res);
    assign w_q    = r_qneg ? (~u_res + 1'b1) : u_res;

    // Result must fit the 32-bit numerator and 31-bit denominator
    generate
        if (WIDTH > FLD_W) begin : g_fit
            assign w_fit = ((&r_cn[WIDTH-1:DEN_W]) || !(|r_cn[WIDTH-1:DEN_W]))
                           && !(|r_cd[WIDTH-1:DEN_W]);
        end else begin : g_nofit
            assign w_fit = 1'b1;
        end
    endgenerate

    assign w_ok       = r_cok && w_fit;
    assign w_out_free = !r_ovalid || i_m_tready;

    rau_unit #(.WIDTH(WIDTH)) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_x     (w_ux),
        .i_y     (w_uy),
        .o_stat  (u_stat),
        .o_res   (u_res)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= w_load || (r_ovalid && !i_m_tready);
        end
    end

    // Working registers and output register
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_cmd   <= n_cmd;
        r_an    <= n_an;
        r_ad    <= n_ad;
        r_bn    <= n_bn;
        r_bd    <= n_bd;
        r_cn    <= n_cn;
        r_cd    <= n_cd;
        r_t     <= n_t;
        r_ng    <= n_ng;
        r_cok   <= n_cok;
        r_qneg  <= n_qneg;
        if (w_load) begin
            r_onum  <= w_ok ? FLD_W'($signed(r_cn)) : '0;
            r_oden  <= w_ok ? DEN_W'(r_cd) : DEN_W'(1);
            r_ostat <= !w_ok;
        end
    end

    // Sequencer: next state and unit requests
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_an    = r_an;
        n_ad    = r_ad;
        n_bn    = r_bn;
        n_bd    = r_bd;
        n_cn    = r_cn;
        n_cd    = r_cd;
        n_t     = r_t;
        n_ng    = r_ng;
        n_cok   = r_cok;
        n_qneg  = r_qneg;
        w_req   = '{start: 1'b0, op: U_MUL};
        w_ux    = r_cn;
        w_uy    = r_cd;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd = w_cmd;
                    n_an  = WIDTH'(w_a_num);
                    n_ad  = WIDTH'(w_a_den);
                    n_bn  = WIDTH'(w_b_num);
                    n_bd  = WIDTH'(w_b_den);
                    n_cn  = WIDTH'(w_a_num);
                    n_cd  = WIDTH'(w_a_den);
                    if (w_cmd == CMD_NORM) begin
                        n_phase = PH_R;
                        n_state = S_C0;
                    end else if (w_cmd <= CMD_DIV) begin
                        n_phase = PH_A;
                        n_state = S_C0;
                    end else begin
                        n_cok   = 1'b0;
                        n_phase = PH_R;
                        n_state = S_CRET;
                    end
                end
            end
            // Canonical form: fold sign, gcd, divide both parts
            S_C0: begin
                if (r_cd == '0) begin
                    n_cok   = 1'b0;
                    n_state = S_CRET;
                end else begin
                    n_cn    = w_nm;
                    n_cd    = w_dm;
                    n_ng    = w_n1[WIDTH-1];
                    w_req   = '{start: 1'b1, op: U_GCD};
                    w_ux    = w_nm;
                    w_uy    = w_dm;
                    n_state = S_C1;
                end
            end
            S_C1: begin
                if (u_stat.done) begin
                    n_t     = u_res;
                    w_req   = '{start: 1'b1, op: U_DIV};
                    w_ux    = r_cn;
                    w_uy    = u_res;
                    n_state = S_C2;
                end
            end
            S_C2: begin
                if (u_stat.done) begin
                    n_cn    = u_res;
                    w_req   = '{start: 1'b1, op: U_DIV};
                    w_ux    = r_cd;
                    w_uy    = r_t;
                    n_state = S_C3;
                end
            end
            S_C3: begin
                if (u_stat.done) begin
                    if (u_res == WSIGN) begin
                        n_cok = 1'b0;
                    end else begin
                        n_cok = 1'b1;
                        n_cd  = u_res;
                        n_cn  = r_ng ? (~r_cn + 1'b1) : r_cn;
                    end
                    n_state = S_CRET;
                end
            end
            // Dispatch after a canonical form completes
            S_CRET: begin
                unique case (r_phase)
                    PH_A: begin
                        n_an    = w_opn;
                        n_ad    = w_opd;
                        n_cn    = r_bn;
                        n_cd    = r_bd;
                        n_phase = PH_B;
                        n_state = S_C0;
                    end
                    PH_B: begin
                        n_bn = w_opn;
                        n_bd = w_opd;
                        case (r_cmd)
                            CMD_ADD, CMD_SUB: begin
                                w_req   = '{start: 1'b1, op: U_GCD};
                                w_ux    = r_ad;
                                w_uy    = w_opd;
                                n_state = S_ADD_G;
                            end
                            CMD_MUL: begin
                                w_req   = '{start: 1'b1, op: U_MUL};
                                w_ux    = r_an;
                                w_uy    = w_opn;
                                n_state = S_MUL1;
                            end
                            default: begin
                                w_req   = '{start: 1'b1, op: U_MUL};
                                w_ux    = r_an;
                                w_uy    = w_opd;
                                n_state = S_MUL1;
                            end
                        endcase
                    end
                    default: begin
                        if (w_out_free) begin
                            w_load  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            // Multiply and divide: cross products
            S_MUL1: begin
                if (u_stat.done) begin
                    n_t     = u_res;
                    w_req   = '{start: 1'b1, op: U_MUL};
                    w_ux    = r_ad;
                    w_uy    = (r_cmd == CMD_MUL) ? r_bd : r_bn;
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                if (u_stat.done) begin
                    n_cn    = r_t;
                    n_cd    = u_res;
                    n_phase = PH_R;
                    n_state = S_C0;
                end
            end
            // Add and subtract: lcm, scale both numerators
            S_ADD_G: begin
                if (u_stat.done) begin
                    w_req   = '{start: 1'b1, op: U_DIV};
                    w_ux    = r_ad;
                    w_uy    = u_res;
                    n_state = S_ADD_D;
                end
            end
            S_ADD_D: begin
                if (u_stat.done) begin
                    w_req   = '{start: 1'b1, op: U_MUL};
                    w_ux    = u_res;
                    w_uy    = r_bd;
                    n_state = S_ADD_L;
                end
            end
            S_ADD_L: begin
                if (u_stat.done) begin
                    n_cd    = w_umag;
                    w_req   = '{start: 1'b1, op: U_MUL};
                    w_ux    = r_an;
                    w_uy    = w_umag;
                    n_state = S_T1M;
                end
            end
            S_T1M: begin
                if (u_stat.done) begin
                    n_qneg  = u_res[WIDTH-1];
                    w_req   = '{start: 1'b1, op: U_DIV};
                    w_ux    = w_umag;
                    w_uy    = r_ad;
                    n_state = S_T1D;
                end
            end
            S_T1D: begin
                if (u_stat.done) begin
                    n_t     = w_q;
                    w_req   = '{start: 1'b1, op: U_MUL};
                    w_ux    = r_bn;
                    w_uy    = r_cd;
                    n_state = S_T2M;
                end
            end
            S_T2M: begin
                if (u_stat.done) begin
                    n_qneg  = u_res[WIDTH-1];
                    w_req   = '{start: 1'b1, op: U_DIV};
                    w_ux    = w_umag;
                    w_uy    = r_bd;
                    n_state = S_T2D;
                end
            end
            S_T2D: begin
                if (u_stat.done) begin
                    n_cn    = (r_cmd == CMD_ADD) ? (r_t + w_q) : (r_t - w_q);
                    n_phase = PH_R;
                    n_state = S_C0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_ostat, r_oden, r_onum};

    // A new operation is never issued while the unit is still working
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req.start && u_stat.busy))
        else $error("unit started while busy");

    // A delivered denominator is never zero
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[62:32] != '0))
        else $error("zero result denominator");

    // An error result is always 0/1
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[63]) |->
            (o_m_tdata[31:0] == '0 && o_m_tdata[62:32] == 31'd1))
        else $error("error result not 0/1");

endmodule

// ===== tb/sv/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// Watches both streams of the rational arithmetic unit, computes the reduced
// fraction each accepted command should give and compares every output
// transfer with the oldest pending fraction, field by field.
// ----------------------------------------------------------------------------
module rau_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [rau_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [rau_pkg::OUT_W-1:0] i_m_tdata,
    output int                        o_errors,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    typedef struct packed {
        logic        status;
        logic [30:0] den;
        logic [31:0] num;
    } t_frac_out;

    t_frac_out pending_fracs[$];
    int        errors = 0;

    assign o_errors  = errors;

    function automatic logic [31:0] mag32(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] gcd32(logic [31:0] x, logic [31:0] y);
        logic [31:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduce n/d; a zero or 2^31 reduced denominator fails
    function automatic bit reduce(logic [31:0] n, logic [31:0] d,
                                  output logic [31:0] on, output logic [31:0] od);
        logic [31:0] nm, dm, g;
        bit          ng;
        on = 0;
        od = 1;
        if (d == 0) return 0;
        if (d[31]) n = -n;
        dm = mag32(d);
        ng = n[31];
        nm = mag32(n);
        g  = gcd32(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if (dm == 32'h8000_0000) return 0;
        on = ng ? -nm : nm;
        od = dm;
        return 1;
    endfunction

    function automatic logic [31:0] sdiv32(logic [31:0] a, logic [31:0] b);
        logic [31:0] q;
        if (b == 0) return 0;
        q = mag32(a) / mag32(b);
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_frac_out compute_frac(logic [IN_W-1:0] d);
        logic [2:0]  cmd;
        logic [31:0] an, ad, bn, bd, rn, rd, g, lcm, t1, t2;
        bit          ok;
        t_frac_out   r;
        cmd = d[2:0];
        ok  = 0;
        rn  = 0;
        rd  = 1;
        if (cmd == CMD_NORM) begin
            ok = reduce(d[34:3], d[66:35], rn, rd);
        end else if (cmd <= CMD_DIV) begin
            if (!reduce(d[34:3], d[66:35], an, ad)) begin
                an = 0; ad = 1;
            end
            if (!reduce(d[98:67], d[130:99], bn, bd)) begin
                bn = 0; bd = 1;
            end
            if (cmd == CMD_ADD || cmd == CMD_SUB) begin
                g   = gcd32(ad, bd);
                lcm = (ad / g) * bd;
                if (lcm[31]) lcm = -lcm;
                t1  = sdiv32(an * lcm, ad);
                t2  = sdiv32(bn * lcm, bd);
                t1  = (cmd == CMD_ADD) ? t1 + t2 : t1 - t2;
                ok  = reduce(t1, lcm, rn, rd);
            end else if (cmd == CMD_MUL) begin
                ok = reduce(an * bn, ad * bd, rn, rd);
            end else begin
                ok = reduce(an * bd, ad * bn, rn, rd);
            end
        end
        r.status = !ok;
        r.num    = ok ? rn : 32'd0;
        r.den    = ok ? rd[30:0] : 31'd1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    // Predict on input transfers, check on output transfers
    always @(posedge i_clk) begin
        t_frac_out got, want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                pending_fracs.push_back(compute_frac(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (pending_fracs.size() == 0) begin
                    report_mismatch("unexpected transfer", i_m_tdata[31:0], 0);
                end else begin
                    want = pending_fracs.pop_front();
                    if (got.num != want.num)
                        report_mismatch("res_num", got.num, want.num);
                    if (got.den != want.den)
                        report_mismatch("res_den", {1'b0, got.den}, {1'b0, want.den});
                    if (got.status != want.status)
                        report_mismatch("status", {31'd0, got.status}, {31'd0, want.status});
                end
            end
        end
        o_pending = pending_fracs.size();
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random fraction commands into the rational arithmetic
// unit under varying source and sink idling and backpressure; the checker
// beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               s_tvalid = 0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 0;
    logic [OUT_W-1:0]   m_tdata;
    int                 errors, pending;
    int                 src_idle_pct = 0, snk_idle_pct = 0;
    int                 snk_hold = 0;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    rational_arithmetic_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    rau_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    // Sink: random stalls, or a long counted hold-off
    always @(negedge i_clk) begin
        if (snk_hold > 0) begin
            m_tready <= 0;
            snk_hold <= snk_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic logic [31:0] rand_part();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(2);
            2: return 32'h7FFF_FFFF - $urandom_range(2);
            3: return $urandom_range(4) - 2;
            default: return $signed($urandom_range(2000)) - 1000;
        endcase
    endfunction

    // Offer one item and hold it until transferred; valid stays up after
    // the transfer until the next call or source_idle drops or replaces it
    task automatic send_item(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 0;
            @(negedge i_clk);
        end
        s_tdata  <= {5'd0, bd, bn, ad, an, cmd};
        s_tvalid <= 1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid once no further item follows
    task automatic source_idle();
        s_tvalid <= 0;
    endtask

    task automatic send_random(int n);
        logic [2:0] cmd;
        repeat (n) begin
            cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
            send_item(cmd, rand_part(), rand_part(), rand_part(), rand_part());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: each command, zero denominators, extremes, unused codes
        send_item(CMD_ADD, 1, 2, 1, 3);
        send_item(CMD_SUB, 1, 2, 1, 2);
        send_item(CMD_MUL, -3, 4, 8, -9);
        send_item(CMD_DIV, 2, 3, 4, 5);
        send_item(CMD_NORM, 6, -8, 0, 0);
        send_item(CMD_NORM, 5, 0, 1, 1);
        send_item(CMD_NORM, 0, 7, 1, 1);
        send_item(CMD_ADD, 1, 0, 3, 4);
        send_item(CMD_DIV, 1, 2, 0, 5);
        send_item(CMD_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
        send_item(CMD_NORM, 1, 32'h8000_0000, 0, 0);
        send_item(CMD_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_item(CMD_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
        send_item(CMD_MUL, 1, 65536, 1, 65536);
        send_item(CMD_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE);
        send_item(CMD_SUB, 32'h8000_0000, 1, 1, 1);
        send_item(CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(3'd5, 1, 1, 1, 1);
        send_item(3'd6, 1, 1, 1, 1);
        send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Sink holds off while the source keeps offering
        snk_hold <= 3000;
        send_random(10);
        source_idle();
        while (pending != 0) @(negedge i_clk);

        src_idle_pct = 35; snk_idle_pct = 52;
        send_random(460);
        // Source pauses until the unit drains
        source_idle();
        while (pending != 0) @(negedge i_clk);
        src_idle_pct = 52; snk_idle_pct = 35;
        send_random(460);
        src_idle_pct = 0; snk_idle_pct = 0;
        send_random(460);
        source_idle();

        while (pending != 0) @(negedge i_clk);
        repeat (700) @(negedge i_clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Timeout: 1410 items plus stalls, with wide margin
    initial begin
        #60_000_000;
        $display("tb_top failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/rau_pkg.sv
rtl/rau_unit.sv
rtl/rational_arithmetic_unit.sv
tb/sv/rau_checker.sv
tb/sv/tb_top.sv
